/* rtl/ctp_pkg.sv */
// ----------------------------------------------------------------------------
// ctp_pkg
// Shared widths, register indexes and types for the cubic trajectory point unit.
// ----------------------------------------------------------------------------
package ctp_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_START_TICK     = 3'd0;
    localparam logic [2:0] REG_END_TICK       = 3'd1;
    localparam logic [2:0] REG_START_POSITION = 3'd2;
    localparam logic [2:0] REG_START_SLOPE    = 3'd3;
    localparam logic [2:0] REG_END_POSITION   = 3'd4;
    localparam logic [2:0] REG_END_SLOPE      = 3'd5;
    localparam logic [2:0] REG_TICK_RATE      = 3'd6;

    localparam logic [15:0] TICK_RATE_RESET = 16'd1000;

    // shifted numerator width and divisor (2*D^3) width
    localparam int N_W       = 168;
    localparam int Q_W       = 97;
    // quotient bits, one per divider stage after the range check
    localparam int DIV_STEPS = 32;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic hi;
        logic lo;
    } clip_t;

endpackage

/* rtl/cubic_trajectory_point_unit.sv */
// ----------------------------------------------------------------------------
// cubic_trajectory_point_unit
// Cubic (Hermite) segment evaluator: position and velocity at one tick.
// ----------------------------------------------------------------------------
// Takes one tick per transaction and returns one position/velocity pair,
// signed Q16.16, rounded to nearest (ties up) and saturated. It takes one
// transaction per clock while the output is not stalled; there are 47 register
// stages, the last one the output register. Among them are three Horner
// multiply waves (two stages each, sliced into 33x33 products), the numerator
// add stages and a 33-stage restoring divider (one range check plus one
// quotient bit per stage) dividing by 2*D^3.
// Each stage has its own valid bit, so bubbles close up while the output is
// stalled. Segment terms that depend only on configuration (D^2, D^3, the
// cubic coefficients, x0*D^3, v0*D^3) run on a free-running side chain and are
// settled before a transaction accepted right after a register write needs them.
// Ticks before start_tick give start_position, ticks at or past end_tick give
// end_position, velocity zero in both; an empty window never uses a quotient.
// ----------------------------------------------------------------------------
module cubic_trajectory_point_unit (
    input  logic        aclk,
    input  logic        aresetn,

    // input: [31:0] now_tick
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,

    // output: [31:0] position, [63:32] velocity
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,
    // output flags: [0] saturated
    output logic        m_tuser,

    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wr_data
);

    localparam int NST = 47;    // stages, last one is the output register
    localparam int NW  = ctp_pkg::N_W;

    // ---------------- configuration registers ----------------
    logic [31:0]        start_tick_reg, end_tick_reg;
    logic signed [31:0] x0_reg, v0_reg, xf_reg, vf_reg;
    logic [15:0]        rate_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_tick_reg <= '0;
            end_tick_reg   <= '0;
            x0_reg         <= '0;
            v0_reg         <= '0;
            xf_reg         <= '0;
            vf_reg         <= '0;
            rate_reg       <= ctp_pkg::TICK_RATE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ctp_pkg::REG_START_TICK:     start_tick_reg <= cfg_wr_data;
                ctp_pkg::REG_END_TICK:       end_tick_reg   <= cfg_wr_data;
                ctp_pkg::REG_START_POSITION: x0_reg         <= cfg_wr_data;
                ctp_pkg::REG_START_SLOPE:    v0_reg         <= cfg_wr_data;
                ctp_pkg::REG_END_POSITION:   xf_reg         <= cfg_wr_data;
                ctp_pkg::REG_END_SLOPE:      vf_reg         <= cfg_wr_data;
                ctp_pkg::REG_TICK_RATE:      rate_reg       <= cfg_wr_data[15:0];
                default: ;
            endcase
        end
    end

    // ---------------- segment terms (free running) ----------------
    // depth = register levels from the config registers
    logic [31:0]        span;           // D
    logic signed [32:0] span_b;
    logic signed [32:0] dx;             // xf - x0
    logic signed [33:0] c1;             // 2*v0 + vf
    logic signed [32:0] c2;             // v0 + vf
    logic signed [34:0] t3c2;           // 3*c2
    logic signed [35:0] six_dx;

    assign span   = end_tick_reg - start_tick_reg;
    assign span_b = {1'b0, span};
    assign dx     = 33'(xf_reg) - 33'(x0_reg);
    assign c1     = 34'(v0_reg) + 34'(v0_reg) + 34'(vf_reg);
    assign c2     = 33'(v0_reg) + 33'(vf_reg);
    assign t3c2   = 35'(c2) + 35'(c2) + 35'(c2);
    assign six_dx = (36'(dx) <<< 2) + (36'(dx) <<< 1);

    logic signed [65:0]  d2_p;          // D^2, depth 2
    logic signed [66:0]  c1d_p;         // c1*D, depth 2
    logic signed [65:0]  c2d_p;         // c2*D, depth 2
    logic signed [68:0]  g_p;           // 6*dx*rate, depth 2
    logic signed [97:0]  d3_p;          // D^3, depth 4
    logic signed [98:0]  ad_p;          // a*D, depth 5
    logic signed [129:0] x0d3_p;        // x0*D^3, depth 6
    logic signed [129:0] v0d3_p;        // v0*D^3, depth 6

    logic signed [65:0]  a_reg;         // 3dx - c1*D, depth 3
    logic signed [65:0]  b_reg;         // c2*D - 2dx, depth 3
    logic signed [67:0]  c1d2_reg;      // 2*c1*D, depth 3
    logic signed [129:0] off_reg;       // D^3 * (2^32 + 1), depth 5
    logic signed [51:0]  g52;
    logic [ctp_pkg::Q_W-1:0] den;       // 2*D^3, depth 4

    ctp_mul #(.WA(33)) u_mul_d2 (
        .aclk(aclk), .en_pp(1'b1), .en_sum(1'b1), .a(span_b), .b(span_b), .p(d2_p));
    ctp_mul #(.WA(34)) u_mul_c1d (
        .aclk(aclk), .en_pp(1'b1), .en_sum(1'b1), .a(c1), .b(span_b), .p(c1d_p));
    ctp_mul #(.WA(33)) u_mul_c2d (
        .aclk(aclk), .en_pp(1'b1), .en_sum(1'b1), .a(c2), .b(span_b), .p(c2d_p));
    ctp_mul #(.WA(36)) u_mul_g (
        .aclk(aclk), .en_pp(1'b1), .en_sum(1'b1), .a(six_dx),
        .b({17'd0, rate_reg}), .p(g_p));
    ctp_mul #(.WA(65)) u_mul_d3 (
        .aclk(aclk), .en_pp(1'b1), .en_sum(1'b1), .a(65'(d2_p)), .b(span_b), .p(d3_p));
    ctp_mul #(.WA(66)) u_mul_ad (
        .aclk(aclk), .en_pp(1'b1), .en_sum(1'b1), .a(a_reg), .b(span_b), .p(ad_p));
    ctp_mul #(.WA(97)) u_mul_x0d3 (
        .aclk(aclk), .en_pp(1'b1), .en_sum(1'b1), .a(97'(d3_p)),
        .b(33'(x0_reg)), .p(x0d3_p));
    ctp_mul #(.WA(97)) u_mul_v0d3 (
        .aclk(aclk), .en_pp(1'b1), .en_sum(1'b1), .a(97'(d3_p)),
        .b(33'(v0_reg)), .p(v0d3_p));

    always_ff @(posedge aclk) begin
        a_reg    <= 66'(dx) * 3 - 66'(c1d_p);
        b_reg    <= 66'(c2d_p) - 66'(dx) * 2;
        c1d2_reg <= 68'(c1d_p) <<< 1;
        off_reg  <= (130'(d3_p) <<< 32) + 130'(d3_p);
    end

    assign g52 = 52'(g_p);
    assign den = {d3_p[95:0], 1'b0};

    // ---------------- stage control ----------------
    logic [NST:1] vld_reg;
    logic [NST:1] en;

    // a stage loads when it is empty, some later stage has room, or the output is taken
    for (genvar k = 1; k <= NST; k++) begin : g_en
        assign en[k] = m_tready | ~(&vld_reg[NST:k]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[1]) begin
                vld_reg[1] <= s_tvalid;
            end
            for (int k = 2; k <= NST; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign s_tready = en[1];
    assign m_tvalid = vld_reg[NST];

    // ---------------- item path ----------------
    logic [31:0]  s_reg   [1:9];        // now - start
    logic [31:0]  dms_reg [1:3];        // end - now
    logic [46:1]  inside_reg;
    logic [46:1]  before_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            s_reg[1]      <= s_tdata - start_tick_reg;
            dms_reg[1]    <= end_tick_reg - s_tdata;
            before_reg[1] <= s_tdata < start_tick_reg;
            inside_reg[1] <= !(s_tdata < start_tick_reg) && (s_tdata < end_tick_reg);
        end
        for (int k = 2; k <= 9; k++) begin
            if (en[k]) begin
                s_reg[k] <= s_reg[k-1];
            end
        end
        for (int k = 2; k <= 3; k++) begin
            if (en[k]) begin
                dms_reg[k] <= dms_reg[k-1];
            end
        end
        for (int k = 2; k <= 46; k++) begin
            if (en[k]) begin
                before_reg[k] <= before_reg[k-1];
                inside_reg[k] <= inside_reg[k-1];
            end
        end
    end

    // wave 1 (stages 4-5): b*s, 3*c2*s, g*(D-s)
    logic signed [98:0] bs_p;
    logic signed [67:0] e_p;
    logic signed [84:0] k2_p;

    ctp_mul #(.WA(66)) u_mul_bs (
        .aclk(aclk), .en_pp(en[4]), .en_sum(en[5]), .a(b_reg),
        .b({1'b0, s_reg[3]}), .p(bs_p));
    ctp_mul #(.WA(35)) u_mul_e (
        .aclk(aclk), .en_pp(en[4]), .en_sum(en[5]), .a(t3c2),
        .b({1'b0, s_reg[3]}), .p(e_p));
    ctp_mul #(.WA(52)) u_mul_k2 (
        .aclk(aclk), .en_pp(en[4]), .en_sum(en[5]), .a(g52),
        .b({1'b0, dms_reg[3]}), .p(k2_p));

    // stage 6: h = a*D + b*s, f = 3*c2*s - 2*c1*D
    logic signed [98:0] h_reg;
    logic signed [67:0] f_reg;
    logic signed [84:0] k2_reg [6:8];

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            h_reg     <= ad_p + bs_p;
            f_reg     <= e_p - c1d2_reg;
            k2_reg[6] <= k2_p;
        end
        for (int k = 7; k <= 8; k++) begin
            if (en[k]) begin
                k2_reg[k] <= k2_reg[k-1];
            end
        end
    end

    // wave 2 (stages 7-8): h*s, f*D
    logic signed [131:0] hs_p;
    logic signed [100:0] k1_p;

    ctp_mul #(.WA(99)) u_mul_hs (
        .aclk(aclk), .en_pp(en[7]), .en_sum(en[8]), .a(h_reg),
        .b({1'b0, s_reg[6]}), .p(hs_p));
    ctp_mul #(.WA(68)) u_mul_k1 (
        .aclk(aclk), .en_pp(en[7]), .en_sum(en[8]), .a(f_reg),
        .b(span_b), .p(k1_p));

    // stage 9: h2 = v0*D^3 + s*h, k = D*f + g*(D-s)
    logic signed [131:0] h2_reg;
    logic signed [100:0] k_reg;

    always_ff @(posedge aclk) begin
        if (en[9]) begin
            h2_reg <= hs_p + 132'(v0d3_p);
            k_reg  <= k1_p + 101'(k2_reg[8]);
        end
    end

    // wave 3 (stages 10-11): h2*s, k*s
    logic signed [164:0] ps_p;
    logic signed [133:0] vs_p;

    ctp_mul #(.WA(132)) u_mul_ps (
        .aclk(aclk), .en_pp(en[10]), .en_sum(en[11]), .a(h2_reg),
        .b({1'b0, s_reg[9]}), .p(ps_p));
    ctp_mul #(.WA(101)) u_mul_vs (
        .aclk(aclk), .en_pp(en[10]), .en_sum(en[11]), .a(k_reg),
        .b({1'b0, s_reg[9]}), .p(vs_p));

    // stage 12: numerators over D^3; stage 13: 2N + D^3 + 2^32*D^3
    logic signed [NW-1:0] pn_reg, vn_reg;
    logic signed [NW-1:0] pq_reg, vq_reg;

    always_ff @(posedge aclk) begin
        if (en[12]) begin
            pn_reg <= NW'(ps_p) + NW'(x0d3_p);
            vn_reg <= NW'(vs_p) + NW'(v0d3_p);
        end
        if (en[13]) begin
            pq_reg <= (pn_reg <<< 1) + NW'(off_reg);
            vq_reg <= (vn_reg <<< 1) + NW'(off_reg);
        end
    end

    // stages 14-46: range check and quotient bits
    logic [31:0]    pquo, vquo;
    ctp_pkg::clip_t pclip, vclip;

    ctp_div u_div_pos (
        .aclk(aclk), .en(en[46:14]), .num(pq_reg), .den(den),
        .quo(pquo), .clip(pclip));
    ctp_div u_div_vel (
        .aclk(aclk), .en(en[46:14]), .num(vq_reg), .den(den),
        .quo(vquo), .clip(vclip));

    // stage 47: output register
    logic signed [31:0] pos_next, vel_next, pos_reg, vel_reg;
    logic               sat_next, sat_reg;

    always_comb begin
        pos_next = xf_reg;
        vel_next = '0;
        sat_next = 1'b0;
        if (inside_reg[46]) begin
            // quotient was offset by 2^31: flip the top bit back
            if (pclip.hi) begin
                pos_next = ctp_pkg::SAT_MAX;
            end else if (pclip.lo) begin
                pos_next = ctp_pkg::SAT_MIN;
            end else begin
                pos_next = {~pquo[31], pquo[30:0]};
            end
            if (vclip.hi) begin
                vel_next = ctp_pkg::SAT_MAX;
            end else if (vclip.lo) begin
                vel_next = ctp_pkg::SAT_MIN;
            end else begin
                vel_next = {~vquo[31], vquo[30:0]};
            end
            sat_next = pclip.hi | pclip.lo | vclip.hi | vclip.lo;
        end else if (before_reg[46]) begin
            pos_next = x0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[NST]) begin
            pos_reg <= pos_next;
            vel_reg <= vel_next;
            sat_reg <= sat_next;
        end
    end

    assign m_tdata = {vel_reg, pos_reg};
    assign m_tuser = sat_reg;

endmodule

/* rtl/ctp_mul.sv */
// ----------------------------------------------------------------------------
// ctp_mul
// Two-stage signed multiplier: wide operand times 33-bit signed operand,
// split into 32-bit slices, partial products registered, then summed.
// ----------------------------------------------------------------------------
module ctp_mul #(
    parameter int WA = 64
) (
    input  logic                   aclk,
    input  logic                   en_pp,
    input  logic                   en_sum,
    input  logic signed [WA-1:0]   a,
    input  logic signed [32:0]     b,
    output logic signed [WA+32:0]  p
);

    localparam int NC = (WA + 31) / 32;
    localparam int WX = NC * 32 + 1;
    localparam int WP = WA + 33;

    logic signed [WX-1:0] ax;
    logic signed [32:0]   slice [NC];
    logic signed [65:0]   pp_reg [NC];
    logic signed [WP-1:0] sum_next;
    logic signed [WP-1:0] p_reg;

    assign ax = WX'(a);

    // low slices are unsigned, the top slice carries the sign
    for (genvar i = 0; i < NC; i++) begin : g_slice
        if (i == NC - 1) begin : g_top
            assign slice[i] = ax[32*i +: 33];
        end else begin : g_low
            assign slice[i] = {1'b0, ax[32*i +: 32]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en_pp) begin
            for (int i = 0; i < NC; i++) begin
                pp_reg[i] <= slice[i] * b;
            end
        end
    end

    always_comb begin
        sum_next = '0;
        for (int i = 0; i < NC; i++) begin
            sum_next = sum_next + (WP'(pp_reg[i]) <<< (32 * i));
        end
    end

    always_ff @(posedge aclk) begin
        if (en_sum) begin
            p_reg <= sum_next;
        end
    end

    assign p = p_reg;

endmodule

/* rtl/ctp_div.sv */
// ----------------------------------------------------------------------------
// ctp_div
// Pipelined restoring divider: range check stage, then one quotient bit
// per stage. Numerator is offset so a fitting quotient is 0..2^32-1.
// ----------------------------------------------------------------------------
module ctp_div (
    input  logic                                aclk,
    input  logic [ctp_pkg::DIV_STEPS:0]         en,
    input  logic signed [ctp_pkg::N_W-1:0]      num,
    input  logic [ctp_pkg::Q_W-1:0]             den,
    output logic [ctp_pkg::DIV_STEPS-1:0]       quo,
    output ctp_pkg::clip_t                      clip
);

    localparam int NS = ctp_pkg::DIV_STEPS;
    localparam int QW = ctp_pkg::Q_W;
    localparam int NW = ctp_pkg::N_W;

    logic [QW-1:0]      rem_reg  [NS+1];
    logic [NS-1:0]      lq_reg   [NS+1];
    ctp_pkg::clip_t     clip_reg [NS+1];

    logic               big;

    // quotient overflows high when num / 2^32 reaches the divisor
    assign big = num[NW-1:NS] >= (NW-NS)'(den);

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            rem_reg[0]     <= num[NS+QW-1:NS];
            lq_reg[0]      <= num[NS-1:0];
            clip_reg[0].lo <= num[NW-1];
            clip_reg[0].hi <= !num[NW-1] && big;
        end
    end

    // low word shifts out numerator bits and shifts in quotient bits
    for (genvar j = 1; j <= NS; j++) begin : g_step
        logic [QW:0] r2;
        logic [QW:0] dif;
        logic        ge;

        assign r2  = {rem_reg[j-1], lq_reg[j-1][NS-1]};
        assign dif = r2 - {1'b0, den};
        assign ge  = r2 >= {1'b0, den};

        always_ff @(posedge aclk) begin
            if (en[j]) begin
                rem_reg[j]  <= ge ? dif[QW-1:0] : r2[QW-1:0];
                lq_reg[j]   <= {lq_reg[j-1][NS-2:0], ge};
                clip_reg[j] <= clip_reg[j-1];
            end
        end
    end

    assign quo  = lq_reg[NS];
    assign clip = clip_reg[NS];

endmodule
